[sv/svt_pkg.sv]
package svt_pkg;

    // Operation codes carried in the opcode field.
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_CREATE = 2'd1;
    localparam logic [1:0] OP_FREE   = 2'd2;

    // Error codes reported with a result.
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OUT_MEM  = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    // Highest scope level that a create accepts.
    localparam int LEVEL_LIMIT = 127;

    // Level code that marks a global entry.
    localparam logic [7:0] LEVEL_GLOBAL = 8'hFF;

    // One stored variable entry.
    typedef struct packed {
        logic [11:0] symbol;
        logic [7:0]  level;
        logic        vtype;
        logic        is_ref;
        logic [15:0] ref_handle;
    } entry_t;

    // Lookup result token that travels toward the top of the stack.
    typedef struct packed {
        logic        valid;
        logic        vtype;
        logic        is_ref;
        logic [15:0] ref_handle;
    } token_t;

    // Commands broadcast from the controller to every cell.
    typedef struct packed {
        logic        load;
        logic        step;
        logic        push;
        logic        pop;
        logic [11:0] key_symbol;
        logic [8:0]  key_level;
        entry_t      new_entry;
    } cell_ctrl_t;

    // One result item, found in the lowest bit.
    typedef struct packed {
        logic [15:0] entry_ref_handle;
        logic        entry_is_ref;
        logic        entry_type;
        logic [8:0]  entry_count;
        logic [1:0]  error_code;
        logic [7:0]  slot;
        logic        found;
    } result_t;

endpackage

[sv/svt_cell.sv]
module svt_cell #(
    parameter int INDEX_W = 8,
    parameter int INDEX   = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  svt_pkg::cell_ctrl_t       ctrl,
    input  logic                      occupied,
    input  svt_pkg::entry_t           up_entry,
    input  svt_pkg::entry_t           down_entry,
    input  svt_pkg::token_t           down_token,
    input  logic [INDEX_W-1:0]        down_index,
    output svt_pkg::entry_t           entry,
    output svt_pkg::token_t           token,
    output logic [INDEX_W-1:0]        token_index
);
    import svt_pkg::*;

    entry_t             entry_reg;
    logic               valid_reg;
    logic               vtype_reg;
    logic               is_ref_reg;
    logic [15:0]        ref_reg;
    logic [INDEX_W-1:0] index_reg;
    logic               hit;

    // This cell holds the wanted symbol at the wanted or the global level.
    assign hit = occupied && (entry_reg.symbol == ctrl.key_symbol)
                 && (({entry_reg.level[7], entry_reg.level} == ctrl.key_level)
                     || (entry_reg.level == LEVEL_GLOBAL));

    // Stack storage: a push takes the entry above, a pop the entry below.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            entry_reg <= up_entry;
        end
        else if (ctrl.pop)
        begin
            entry_reg <= down_entry;
        end
    end

    // Result token: loaded from the local compare, then a miss takes the
    // neighbor's token so that the newest hit reaches the top cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            valid_reg <= hit;
        end
        else if (ctrl.step && !valid_reg)
        begin
            valid_reg <= down_token.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            vtype_reg  <= entry_reg.vtype;
            is_ref_reg <= entry_reg.is_ref;
            ref_reg    <= entry_reg.ref_handle;
            index_reg  <= INDEX_W'(INDEX);
        end
        else if (ctrl.step && !valid_reg)
        begin
            vtype_reg  <= down_token.vtype;
            is_ref_reg <= down_token.is_ref;
            ref_reg    <= down_token.ref_handle;
            index_reg  <= down_index;
        end
    end

    assign entry       = entry_reg;
    assign token       = {valid_reg, vtype_reg, is_ref_reg, ref_reg};
    assign token_index = index_reg;

endmodule

[sv/scoped_variable_table.sv]
// Scoped variable table: a stack of variable entries kept in a row of cells,
// the newest entry in the first cell.
// Input channel s_*: one transfer carries one operation (lookup, create, or
// free down to a level). Output channel m_*: one result transfer for every
// accepted operation, in order.
// A create or an unused opcode goes straight to the result state. A lookup
// does the compare in every cell at once, then the newest hit walks one
// cell per cycle toward the top.
// A free pops one entry from the top of the stack per cycle while the stack
// is not empty and the top entry's level is at or above the given level.
// The next operation is accepted once the result of the previous one has
// been placed in the output register; while a result waits there, one more
// operation may be accepted and processed, and its result is held until
// the receiver takes the waiting one.
// Reset empties the table and the output register; entry storage is not
// cleared, as entries at or above the count are never read.
module scoped_variable_table #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[1:0], symbol[13:2], sub_level[22:14], value_type[23],
    // is_ref[24], ref_handle[40:25], zero fill[47:41]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // found[0], slot[8:1], error_code[10:9], entry_count[19:11],
    // entry_type[20], entry_is_ref[21], entry_ref_handle[37:22],
    // zero fill[39:38]
    output logic [39:0] m_tdata
);
    import svt_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = $clog2(TABLE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_FREE,
        ST_RESULT
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   step_reg, step_next;
    logic [8:0]      lvl_reg, lvl_next;
    result_t         pend_reg, pend_next;
    result_t         out_reg, out_next;
    logic            m_valid_reg, m_valid_next;

    cell_ctrl_t      ctrl;
    entry_t          ent [TABLE_DEPTH];
    token_t          tok [TABLE_DEPTH];
    logic [IW-1:0]   tok_idx [TABLE_DEPTH];

    logic [1:0]      in_opcode;
    logic [11:0]     in_symbol;
    logic [8:0]      in_level;
    logic            in_vtype;
    logic            in_is_ref;
    logic [15:0]     in_ref;
    logic            full;
    logic            over_limit;
    logic            top_at_or_above;
    logic [CW-1:0]   hit_slot;

    // Input field split.
    assign in_opcode = s_tdata[1:0];
    assign in_symbol = s_tdata[13:2];
    assign in_level  = s_tdata[22:14];
    assign in_vtype  = s_tdata[23];
    assign in_is_ref = s_tdata[24];
    assign in_ref    = s_tdata[40:25];

    assign full       = (count_reg == CW'(TABLE_DEPTH));
    assign over_limit = $signed(in_level) > $signed(9'(LEVEL_LIMIT));
    assign top_at_or_above =
        $signed({ent[0].level[7], ent[0].level}) >= $signed(lvl_reg);
    assign hit_slot = count_reg - CW'(1) - CW'(tok_idx[0]);

    // Row of cells.
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        entry_t        up_e;
        entry_t        down_e;
        token_t        down_t;
        logic [IW-1:0] down_i;
        logic          occ;

        assign occ = (CW'(i) < count_reg);

        if (i == 0)
        begin : g_top
            assign up_e = ctrl.new_entry;
        end
        else
        begin : g_mid
            assign up_e = ent[i-1];
        end

        if (i == TABLE_DEPTH - 1)
        begin : g_bottom
            assign down_e = ent[i];
            assign down_t = '0;
            assign down_i = '0;
        end
        else
        begin : g_inner
            assign down_e = ent[i+1];
            assign down_t = tok[i+1];
            assign down_i = tok_idx[i+1];
        end

        svt_cell #(
            .INDEX_W (IW),
            .INDEX   (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .occupied    (occ),
            .up_entry    (up_e),
            .down_entry  (down_e),
            .down_token  (down_t),
            .down_index  (down_i),
            .entry       (ent[i]),
            .token       (tok[i]),
            .token_index (tok_idx[i])
        );
    end

    // Controller: next state, cell commands and result assembly.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        step_next    = step_reg;
        lvl_next     = lvl_reg;
        pend_next    = pend_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_tready;

        ctrl                      = '0;
        ctrl.key_symbol           = in_symbol;
        ctrl.key_level            = in_level;
        ctrl.new_entry.symbol     = in_symbol;
        ctrl.new_entry.level      = in_level[7:0];
        ctrl.new_entry.vtype      = in_vtype;
        ctrl.new_entry.is_ref     = in_is_ref;
        ctrl.new_entry.ref_handle = in_is_ref ? in_ref : 16'd0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    pend_next             = '0;
                    pend_next.entry_count = 9'(count_reg);
                    case (in_opcode)
                        OP_LOOKUP:
                        begin
                            ctrl.load  = 1'b1;
                            step_next  = '0;
                            state_next = ST_LOOK;
                        end
                        OP_CREATE:
                        begin
                            if (full)
                            begin
                                pend_next.error_code = ERR_OUT_MEM;
                            end
                            else if (over_limit)
                            begin
                                pend_next.error_code = ERR_OVERFLOW;
                            end
                            else
                            begin
                                ctrl.push                  = 1'b1;
                                count_next                 = count_reg + CW'(1);
                                pend_next.found            = 1'b1;
                                pend_next.slot             = 8'(count_reg);
                                pend_next.entry_count      = 9'(count_reg + CW'(1));
                                pend_next.entry_type       = in_vtype;
                                pend_next.entry_is_ref     = in_is_ref;
                                pend_next.entry_ref_handle =
                                    in_is_ref ? in_ref : 16'd0;
                            end
                            state_next = ST_RESULT;
                        end
                        OP_FREE:
                        begin
                            lvl_next   = in_level;
                            state_next = ST_FREE;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_LOOK:
            begin
                if (step_reg == count_reg)
                begin
                    if (tok[0].valid)
                    begin
                        pend_next.found            = 1'b1;
                        pend_next.slot             = 8'(hit_slot);
                        pend_next.entry_type       = tok[0].vtype;
                        pend_next.entry_is_ref     = tok[0].is_ref;
                        pend_next.entry_ref_handle = tok[0].ref_handle;
                    end
                    state_next = ST_RESULT;
                end
                else
                begin
                    ctrl.step = 1'b1;
                    step_next = step_reg + CW'(1);
                end
            end
            ST_FREE:
            begin
                if ((count_reg != '0) && top_at_or_above)
                begin
                    ctrl.pop   = 1'b1;
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    pend_next.entry_count = 9'(count_reg);
                    state_next            = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    out_next     = pend_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg  <= lvl_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_reg};

    // The count never passes the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // The lookup walk never runs past the occupied cells.
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOK) |-> (step_reg <= count_reg))
        else $error("lookup walk past the stack top");

    // A free never adds entries.
    a_free_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FREE) |=> (count_reg <= $past(count_reg)))
        else $error("count grew during free");

    // A delivered result never reports success together with an error.
    a_found_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(out_reg.found && (out_reg.error_code != ERR_NONE)))
        else $error("result both found and in error");

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import svt_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int CYCLE_LIMIT = 800000;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One operation as carried in s_tdata, opcode in the lowest bits.
    typedef struct packed {
        logic [6:0]  fill;
        logic [15:0] ref_handle;
        logic        is_ref;
        logic        value_type;
        logic [8:0]  sub_level;
        logic [11:0] symbol;
        logic [1:0]  opcode;
    } var_op_t;

    // Expected outcome attached to an operation when it is sent.
    typedef struct {
        bit      typed;
        result_t want;
    } check_t;

    typedef struct {
        var_op_t op;
        bit      typed;
        result_t want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    // Shadow copy of the variable stack.
    logic [11:0] tbl_symbol [TABLE_DEPTH];
    logic [7:0]  tbl_level  [TABLE_DEPTH];
    logic        tbl_type   [TABLE_DEPTH];
    logic        tbl_is_ref [TABLE_DEPTH];
    logic [15:0] tbl_ref    [TABLE_DEPTH];
    int          tbl_count = 0;

    check_t  issued_checks[$];
    result_t pending_results[$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  burst_left = 0;
    bit  hold_off_req = 1'b0;
    int  n_lookup = 0;
    int  n_hit = 0;
    int  n_create = 0;
    int  n_free = 0;
    int  n_unused = 0;
    int  n_full = 0;
    int  n_level_reject = 0;
    int  peak_depth = 0;

    row_t directed [24];

    scoped_variable_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("scoped_variable_table verification failed");
            $finish;
        end
    end

    function automatic var_op_t make_op(logic [1:0] opc, int sym, int lvl, bit vt, bit ir,
                                        int handle);
        var_op_t op;
        op = '0;
        op.opcode = opc;
        op.symbol = 12'(sym);
        op.sub_level = 9'(lvl);
        op.value_type = vt;
        op.is_ref = ir;
        op.ref_handle = 16'(handle);
        return op;
    endfunction

    // Outcome of an operation on an empty table that pushes nothing.
    function automatic result_t empty_result(logic [1:0] err);
        result_t r;
        r = '0;
        r.error_code = err;
        return r;
    endfunction

    // Applies one operation to the shadow stack and returns its result.
    function automatic result_t table_apply(var_op_t op);
        result_t r;
        int      lvl;
        int      idx;
        bit      hit;
        r = '0;
        lvl = $signed(op.sub_level);
        case (op.opcode)
            OP_LOOKUP:
            begin
                idx = tbl_count - 1;
                hit = 1'b0;
                while (idx >= 0 && !hit)
                begin
                    if (tbl_symbol[idx] == op.symbol &&
                        ($signed(tbl_level[idx]) == lvl || tbl_level[idx] == LEVEL_GLOBAL))
                    begin
                        hit = 1'b1;
                        r.found = 1'b1;
                        r.slot = 8'(idx);
                        r.entry_type = tbl_type[idx];
                        r.entry_is_ref = tbl_is_ref[idx];
                        r.entry_ref_handle = tbl_ref[idx];
                    end
                    idx--;
                end
            end
            OP_CREATE:
            begin
                if (tbl_count >= TABLE_DEPTH)
                    r.error_code = ERR_OUT_MEM;
                else if (lvl > LEVEL_LIMIT)
                    r.error_code = ERR_OVERFLOW;
                else
                begin
                    idx = tbl_count;
                    tbl_symbol[idx] = op.symbol;
                    tbl_level[idx] = op.sub_level[7:0];
                    tbl_type[idx] = op.value_type;
                    tbl_is_ref[idx] = op.is_ref;
                    tbl_ref[idx] = op.is_ref ? op.ref_handle : 16'd0;
                    tbl_count = idx + 1;
                    r.found = 1'b1;
                    r.slot = 8'(idx);
                    r.entry_type = tbl_type[idx];
                    r.entry_is_ref = tbl_is_ref[idx];
                    r.entry_ref_handle = tbl_ref[idx];
                end
            end
            OP_FREE:
            begin
                while (tbl_count > 0 && $signed(tbl_level[tbl_count - 1]) >= lvl)
                    tbl_count--;
            end
            default:
            begin
            end
        endcase
        r.entry_count = 9'(tbl_count);
        return r;
    endfunction

    function automatic string show(result_t r);
        return $sformatf("found=%0d slot=%0d err=%0d count=%0d type=%0d is_ref=%0d handle=%h",
                         r.found, r.slot, r.error_code, r.entry_count, r.entry_type,
                         r.entry_is_ref, r.entry_ref_handle);
    endfunction

    // Input transfers: predict the result of every accepted operation.
    always @(posedge clk)
    begin
        var_op_t acc_op;
        result_t predicted;
        check_t  chk;
        if (rst_n && s_tvalid && s_tready)
        begin
            acc_op = var_op_t'(s_tdata);
            predicted = table_apply(acc_op);
            chk.typed = 1'b0;
            if (issued_checks.size() != 0)
                chk = issued_checks.pop_front();
            pending_results.push_back(chk.typed ? chk.want : predicted);
            case (acc_op.opcode)
                OP_LOOKUP:
                begin
                    n_lookup++;
                    if (predicted.found)
                        n_hit++;
                end
                OP_CREATE:
                begin
                    n_create++;
                    if (predicted.error_code == ERR_OUT_MEM)
                        n_full++;
                    if (predicted.error_code == ERR_OVERFLOW)
                        n_level_reject++;
                end
                OP_FREE: n_free++;
                default: n_unused++;
            endcase
            if (tbl_count > peak_depth)
                peak_depth = tbl_count;
        end
    end

    // Output transfers: compare every result with the oldest expectation.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[37:0];
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result at cycle %0d: %s", cycle_count, show(got));
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.found !== want.found || got.slot !== want.slot ||
                    got.error_code !== want.error_code ||
                    got.entry_count !== want.entry_count ||
                    got.entry_type !== want.entry_type ||
                    got.entry_is_ref !== want.entry_is_ref ||
                    got.entry_ref_handle !== want.entry_ref_handle)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("Mismatch at cycle %0d", cycle_count);
                        $display("  expected %s", show(want));
                        $display("  actual   %s", show(got));
                    end
                end
            end
        end
    end

    // Receiver: randomly chosen stall patterns, plus one long hold-off on request.
    initial
    begin
        int mode;
        int span;
        m_tready = 1'b0;
        mode = 0;
        span = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 2);
                    span = $urandom_range(20, 150);
                end
                span--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= $urandom_range(0, 1);
                endcase
            end
        end
    end

    // Sends one operation in bursts with random gaps, returning at its transfer.
    task automatic send_op(var_op_t op, bit typed, result_t want);
        int     gap;
        check_t chk;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        chk.typed = typed;
        chk.want = want;
        issued_checks.push_back(chk);
        s_tvalid <= 1'b1;
        s_tdata <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic send_checked(var_op_t op);
        send_op(op, 1'b0, '0);
    endtask

    // Stops offering and waits until every expected result has arrived.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (issued_checks.size() != 0 || pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic int pick_symbol();
        return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 15) : $urandom_range(0, 4095);
    endfunction

    function automatic int any_level();
        return $urandom_range(0, 511) - 256;
    endfunction

    // Main stimulus.
    initial
    begin
        int cur_lvl;
        int sel;
        int lvl;
        int creates_left;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;

        // Rows with a typed result act on an empty table; the rest use the shadow stack.
        directed = '{
            '{make_op(OP_LOOKUP, 0, 0, 0, 0, 0), 1'b1, empty_result(ERR_NONE)},
            '{make_op(OP_FREE, 0, 0, 0, 0, 0), 1'b1, empty_result(ERR_NONE)},
            '{make_op(OP_CREATE, 4095, 128, 1, 1, 65535), 1'b1, empty_result(ERR_OVERFLOW)},
            '{make_op(OP_CREATE, 0, 255, 0, 0, 0), 1'b1, empty_result(ERR_OVERFLOW)},
            '{make_op(OP_UNUSED, 4095, -1, 1, 1, 65535), 1'b1, empty_result(ERR_NONE)},
            '{make_op(OP_CREATE, 4095, -1, 1, 1, 65535), 1'b0, '0},
            '{make_op(OP_CREATE, 0, 127, 0, 0, 'hBEEF), 1'b0, '0},
            '{make_op(OP_CREATE, 1, -200, 1, 1, 0), 1'b0, '0},
            '{make_op(OP_LOOKUP, 1, 56, 0, 0, 0), 1'b0, '0},
            '{make_op(OP_LOOKUP, 1, -200, 0, 0, 0), 1'b0, '0},
            '{make_op(OP_LOOKUP, 4095, 200, 0, 0, 0), 1'b0, '0},
            '{make_op(OP_LOOKUP, 0, 127, 0, 0, 0), 1'b0, '0},
            '{make_op(OP_CREATE, 0, 3, 0, 1, 'h1234), 1'b0, '0},
            '{make_op(OP_LOOKUP, 0, 3, 0, 0, 0), 1'b0, '0},
            '{make_op(OP_LOOKUP, 0, 127, 0, 0, 0), 1'b0, '0},
            '{make_op(OP_CREATE, 0, -1, 1, 0, 'hFFFF), 1'b0, '0},
            '{make_op(OP_LOOKUP, 0, 127, 0, 0, 0), 1'b0, '0},
            '{make_op(OP_CREATE, 2, -256, 0, 1, 'h8001), 1'b0, '0},
            '{make_op(OP_CREATE, 3, -129, 1, 0, 0), 1'b0, '0},
            '{make_op(OP_FREE, 0, 100, 0, 0, 0), 1'b0, '0},
            '{make_op(OP_UNUSED, 0, 0, 0, 0, 0), 1'b0, '0},
            '{make_op(OP_FREE, 0, -256, 0, 0, 0), 1'b0, '0},
            '{make_op(OP_LOOKUP, 4095, -1, 0, 0, 0), 1'b1, empty_result(ERR_NONE)},
            '{make_op(OP_FREE, 0, 255, 0, 0, 0), 1'b1, empty_result(ERR_NONE)}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        foreach (directed[i])
            send_op(directed[i].op, directed[i].typed, directed[i].want);

        // Nested scopes: creates, lookups and frees around a moving current level.
        cur_lvl = 0;
        for (int i = 0; i < 150; i++)
        begin
            if (i == 40)
                hold_off_req = 1'b1;
            sel = $urandom_range(0, 99);
            if (sel < 40)
            begin
                case ($urandom_range(0, 9))
                    0: lvl = -1;
                    1: lvl = any_level();
                    2: lvl = $urandom_range(120, 135);
                    default: lvl = cur_lvl;
                endcase
                send_checked(make_op(OP_CREATE, pick_symbol(), lvl, $urandom_range(0, 1),
                                     $urandom_range(0, 1), $urandom_range(0, 65535)));
                if (lvl == cur_lvl && cur_lvl < LEVEL_LIMIT && $urandom_range(0, 3) == 0)
                    cur_lvl++;
            end
            else if (sel < 75)
            begin
                case ($urandom_range(0, 4))
                    0: lvl = $urandom_range(0, cur_lvl);
                    1: lvl = any_level();
                    default: lvl = cur_lvl;
                endcase
                send_checked(make_op(OP_LOOKUP, pick_symbol(), lvl, $urandom_range(0, 1),
                                     $urandom_range(0, 1), $urandom_range(0, 65535)));
            end
            else if (sel < 93)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    lvl = cur_lvl;
                    if (cur_lvl > 0)
                        cur_lvl--;
                end
                else
                    lvl = any_level();
                send_checked(make_op(OP_FREE, pick_symbol(), lvl, $urandom_range(0, 1),
                                     $urandom_range(0, 1), $urandom_range(0, 65535)));
            end
            else
                send_checked(make_op(OP_UNUSED, $urandom_range(0, 4095), any_level(),
                                     $urandom_range(0, 1), $urandom_range(0, 1),
                                     $urandom_range(0, 65535)));
        end

        // Fill the table to capacity, then push past it and empty it again.
        wait_idle();
        creates_left = TABLE_DEPTH - tbl_count + 3;
        while (creates_left > 0)
        begin
            send_checked(make_op(OP_CREATE, pick_symbol(), $urandom_range(0, 383) - 256,
                                 $urandom_range(0, 1), $urandom_range(0, 1),
                                 $urandom_range(0, 65535)));
            creates_left--;
            if ($urandom_range(0, 99) < 12)
                send_checked(make_op(OP_LOOKUP, pick_symbol(), any_level(), 0, 0, 0));
        end
        repeat (4)
            send_checked(make_op(OP_LOOKUP, pick_symbol(), $urandom_range(0, 127), 0, 0, 0));
        send_checked(make_op(OP_FREE, 0, $urandom_range(0, 127), 0, 0, 0));
        send_checked(make_op(OP_FREE, 0, -256, 0, 0, 0));
        send_checked(make_op(OP_LOOKUP, pick_symbol(), -1, 0, 0, 0));

        // Let the last results drain, then allow for the longest lookup.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            mismatch_count++;
            $display("%0d expected results never arrived.", pending_results.size());
        end

        $display("Covered %0d lookups (%0d hits), %0d creates, %0d frees, %0d unused opcodes;",
                 n_lookup, n_hit, n_create, n_free, n_unused);
        $display("%0d table-full and %0d level-limit rejects, peak depth %0d, %0d mismatches.",
                 n_full, n_level_reject, peak_depth, mismatch_count);
        if (mismatch_count == 0)
            $display("scoped_variable_table verification clean");
        else
            $display("scoped_variable_table verification failed");
        $finish;
    end

endmodule
